FILE: rtl/ptik_pkg.sv
`default_nettype none
package ptik_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int STAMP_WIDTH_DEF = 32;
    localparam int ID_W            = 8;
    localparam int LEVEL_W         = 7;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_INCREASE = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic               en;
        op_t                op;
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] amount;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/ptik_cell.sv
`default_nettype none
module ptik_cell #(
    parameter int INDEX       = 0,
    parameter int STAMP_WIDTH = ptik_pkg::STAMP_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ptik_pkg::cmd_t                    cmd,
    input  wire logic [STAMP_WIDTH-1:0]            new_stamp,
    input  wire logic                              found_in,
    input  wire logic [ptik_pkg::LEVEL_W-1:0]      level_in,
    input  wire logic [STAMP_WIDTH-1:0]            stamp_in,
    input  wire logic [ptik_pkg::ID_W-1:0]         id_in,
    output logic                                   found_out,
    output logic [ptik_pkg::LEVEL_W-1:0]           level_out,
    output logic [STAMP_WIDTH-1:0]                 stamp_out,
    output logic [ptik_pkg::ID_W-1:0]              id_out
);
    import ptik_pkg::*;

    logic               valid_reg, valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [STAMP_WIDTH-1:0] stamp_reg, stamp_next;
    logic               found_reg;
    logic [LEVEL_W-1:0] blevel_reg;
    logic [STAMP_WIDTH-1:0] bstamp_reg;
    logic [ID_W-1:0]    bid_reg;
    logic               hit, better;
    logic [LEVEL_W:0]   sum;

    assign hit = cmd.en && (INDEX < 256) && (cmd.id == ID_W'(INDEX));
    assign sum = {1'b0, level_reg} + {1'b0, cmd.amount};

    always_comb
    begin
        valid_next = valid_reg;
        level_next = level_reg;
        stamp_next = stamp_reg;
        if (hit)
        begin
            case (cmd.op)
                OP_INSERT:
                begin
                    valid_next = 1'b1;
                    level_next = (cmd.amount > LEVEL_MAX) ? LEVEL_MAX : cmd.amount;
                    stamp_next = new_stamp;
                end
                OP_INCREASE:
                begin
                    if (valid_reg)
                        level_next = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                               : sum[LEVEL_W-1:0];
                end
                OP_REMOVE: valid_next = 1'b0;
                default: ;
            endcase
        end
    end

    // Keep the incoming best unless this entry is strictly better.
    assign better = valid_reg && (!found_in || (level_reg > level_in) ||
                    ((level_reg == level_in) && (stamp_reg < stamp_in)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            found_reg <= found_in || valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        stamp_reg <= stamp_next;
        if (better)
        begin
            blevel_reg <= level_reg;
            bstamp_reg <= stamp_reg;
            bid_reg    <= ID_W'(INDEX);
        end
        else
        begin
            blevel_reg <= level_in;
            bstamp_reg <= stamp_in;
            bid_reg    <= id_in;
        end
    end

    assign found_out = found_reg;
    assign level_out = blevel_reg;
    assign stamp_out = bstamp_reg;
    assign id_out    = bid_reg;

endmodule
`default_nettype wire

FILE: rtl/priority_table_with_increase_key_unit.sv
`default_nettype none
// Indexed max-priority table. Insert, increase and remove update the addressed
// cell and leave the unit ready for the next request. For a query, the best
// entry ripples through the chain of SLOTS cells, one cell per cycle, then the
// answer goes to the output register. Requests are taken one at a time; a query
// holds off new requests until its result is loaded.
module priority_table_with_increase_key_unit #(
    parameter int SLOTS       = ptik_pkg::SLOTS_DEF,
    parameter int STAMP_WIDTH = ptik_pkg::STAMP_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op[1:0], entry_id[9:2], amount[16:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // top_id[7:0], is_empty[8]
);
    import ptik_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 2);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [STAMP_WIDTH-1:0] ctr_reg;
    logic m_valid_reg;
    logic [ID_W-1:0] top_reg;
    logic empty_reg;
    logic accept, load_out, in_range;
    cmd_t cmd;

    logic               found_c [SLOTS+1];
    logic [LEVEL_W-1:0] level_c [SLOTS+1];
    logic [STAMP_WIDTH-1:0] stamp_c [SLOTS+1];
    logic [ID_W-1:0]    id_c    [SLOTS+1];

    assign accept   = s_tvalid && s_tready;
    assign cmd.en   = accept;
    assign cmd.op   = op_t'(s_tdata[1:0]);
    assign cmd.id   = s_tdata[9:2];
    assign cmd.amount = s_tdata[16:10];
    assign in_range = {24'd0, cmd.id} < 32'(SLOTS);

    assign found_c[0] = 1'b0;
    assign level_c[0] = '0;
    assign stamp_c[0] = '0;
    assign id_c[0]    = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ptik_cell #(.INDEX(i), .STAMP_WIDTH(STAMP_WIDTH)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .new_stamp (ctr_reg),
            .found_in  (found_c[i]),
            .level_in  (level_c[i]),
            .stamp_in  (stamp_c[i]),
            .id_in     (id_c[i]),
            .found_out (found_c[i+1]),
            .level_out (level_c[i+1]),
            .stamp_out (stamp_c[i+1]),
            .id_out    (id_c[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.op == OP_QUERY)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = CNT_W'(SLOTS + 1);
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SEND: load_out = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ctr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (accept && cmd.op == OP_INSERT && in_range)
                ctr_reg <= ctr_reg + 1'b1;
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            top_reg   <= found_c[SLOTS] ? id_c[SLOTS] : '0;
            empty_reg <= !found_c[SLOTS];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, empty_reg, top_reg};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && empty_reg) |-> (top_reg == '0))
        else $error("empty result with nonzero id");
    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_QUERY) |=> (state_reg == ST_SCAN))
        else $error("query did not start scan");

endmodule
`default_nettype wire
